@@ sv/abpq_pkg.sv @@
// ----------------------------------------------------------------------------
// abpq_pkg - shared types and constants for the arrival/burst priority queue
// Job fields, the cell payload and the per-cycle control word for the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package abpq_pkg;

	localparam int unsigned ID_W          = 16;
	localparam int unsigned BURST_W       = 16;
	localparam int unsigned ARR_W         = 32;
	localparam int unsigned QCOUNT_W      = 5;
	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXECUTE = 1'b1
	} op_t;

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic [BURST_W-1:0]      burst;
		logic signed [ARR_W-1:0] arrival;
	} entry_t;

	typedef struct packed {
		logic                shift_in;
		logic                shift_out;
		entry_t              new_entry;
		logic [BURST_W-1:0]  head_burst;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/abpq_if.sv @@
// ----------------------------------------------------------------------------
// abpq_if - job request and result channels
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface abpq_req_if;
	logic                               valid;
	logic                               ready;
	logic                               operation;
	logic [abpq_pkg::ID_W-1:0]          job_id;
	logic [abpq_pkg::BURST_W-1:0]       burst_time;
	logic signed [abpq_pkg::ARR_W-1:0]  arrival_time;

	modport source (output valid, operation, job_id, burst_time, arrival_time,
		input ready);
	modport sink (input valid, operation, job_id, burst_time, arrival_time,
		output ready);
endinterface

interface abpq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               job_valid;
	logic [abpq_pkg::ID_W-1:0]          done_id;
	logic [abpq_pkg::BURST_W-1:0]       done_burst;
	logic                               insert_rejected;
	logic [abpq_pkg::QCOUNT_W-1:0]      queue_count;

	modport source (output valid, job_valid, done_id, done_burst, insert_rejected,
		queue_count, input ready);
	modport sink (input valid, job_valid, done_id, done_burst, insert_rejected,
		queue_count, output ready);
endinterface

`default_nettype wire

@@ sv/abpq_cell.sv @@
// ----------------------------------------------------------------------------
// abpq_cell - one slot of the sorted job queue
// Holds one job; on insert it holds, takes the new job or takes its left
// neighbor; on execute it takes its right neighbor with the arrival reduced.
// ----------------------------------------------------------------------------
`default_nettype none

module abpq_cell (
	input  wire logic                 clk,
	input  wire abpq_pkg::cell_ctrl_t ctrl,
	input  wire logic                 occupied,
	input  wire abpq_pkg::entry_t     prev_entry,
	input  wire logic                 prev_before,
	input  wire abpq_pkg::entry_t     next_entry,
	output abpq_pkg::entry_t          entry,
	output logic                      ahead
);
	import abpq_pkg::*;

	entry_t                entry_q;
	entry_t                entry_d;
	logic signed [ARR_W:0] diff;
	logic                  key_before;

	always_comb begin
		if (entry_q.arrival != ctrl.new_entry.arrival) begin
			key_before = entry_q.arrival < ctrl.new_entry.arrival;
		end else begin
			key_before = entry_q.burst <= ctrl.new_entry.burst;
		end
	end

	assign ahead = occupied & key_before;

	// saturate the reduced arrival at the most negative value
	assign diff = {next_entry.arrival[ARR_W-1], next_entry.arrival}
		- $signed({{(ARR_W+1-BURST_W){1'b0}}, ctrl.head_burst});

	always_comb begin
		entry_d = entry_q;
		if (ctrl.shift_in) begin
			if (!ahead) begin
				entry_d = prev_before ? ctrl.new_entry : prev_entry;
			end
		end else if (ctrl.shift_out) begin
			entry_d = next_entry;
			if (diff[ARR_W] != diff[ARR_W-1]) begin
				entry_d.arrival = {1'b1, {(ARR_W-1){1'b0}}};
			end else begin
				entry_d.arrival = diff[ARR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

@@ sv/arrival_burst_priority_queue.sv @@
// ----------------------------------------------------------------------------
// arrival_burst_priority_queue - sorted job queue for a non-preemptive scheduler
// Jobs sit in a row of cells ordered by arrival, then burst; execute pops the
// head and reduces every remaining arrival by the head's burst.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  req     | in  | operation, job_id, burst_time, arrival_time
//  rsp     | out | job_valid, done_id, done_burst, insert_rejected, queue_count
//
//  One transaction per cycle unless req stalls: every cell compares against the
//  new job at once, the row shifts together; the result is registered.
//  Reset empties the queue (held count cleared); cell contents are not reset.
//  The result register frees up as it is taken, so req stalls only while an
//  unread result is held and rsp.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module arrival_burst_priority_queue #(
	parameter int unsigned QUEUE_DEPTH = abpq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	abpq_req_if.sink   req,
	abpq_rsp_if.source rsp
);
	import abpq_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic               accept;
	logic               full;
	logic               empty;
	cell_ctrl_t         ctrl;
	entry_t             cell_entry [QUEUE_DEPTH];
	logic               cell_before [QUEUE_DEPTH];

	logic               rsp_valid_q;
	logic               job_valid_q;
	logic [ID_W-1:0]    done_id_q;
	logic [BURST_W-1:0] done_burst_q;
	logic               rejected_q;

	assign accept = req.valid && req.ready;
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign req.ready = !rsp_valid_q || rsp.ready;

	always_comb begin
		ctrl.shift_in          = accept && (op_t'(req.operation) == OP_INSERT) && !full;
		ctrl.shift_out         = accept && (op_t'(req.operation) == OP_EXECUTE) && !empty;
		ctrl.new_entry.id      = req.job_id;
		ctrl.new_entry.burst   = req.burst_time;
		ctrl.new_entry.arrival = req.arrival_time;
		ctrl.head_burst        = cell_entry[0].burst;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t prev_e;
		logic   prev_b;
		entry_t next_e;

		if (i == 0) begin : g_first
			assign prev_e = ctrl.new_entry;
			assign prev_b = 1'b0;
		end else begin : g_mid
			assign prev_e = cell_entry[i-1];
			assign prev_b = cell_before[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_e = cell_entry[i];
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end

		abpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (CNT_W'(i) < count_q),
			.prev_entry  (prev_e),
			.prev_before (prev_b),
			.next_entry  (next_e),
			.entry       (cell_entry[i]),
			.ahead       (cell_before[i])
		);
	end

	always_comb begin
		count_d = count_q;
		if (ctrl.shift_in) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctrl.shift_out) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_valid_q  <= ctrl.shift_out;
			done_id_q    <= ctrl.shift_out ? cell_entry[0].id : '0;
			done_burst_q <= ctrl.shift_out ? cell_entry[0].burst : '0;
			rejected_q   <= (op_t'(req.operation) == OP_INSERT) && full;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.job_valid       = job_valid_q;
	assign rsp.done_id         = done_id_q;
	assign rsp.done_burst      = done_burst_q;
	assign rsp.insert_rejected = rejected_q;
	assign rsp.queue_count     = QCOUNT_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("held count above depth");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op_t'(req.operation) == OP_INSERT) && full
		|=> count_q == CNT_W'(QUEUE_DEPTH))
		else $error("rejected insert changed the count");

	a_empty_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op_t'(req.operation) == OP_EXECUTE) && empty
		|=> rsp.valid && !rsp.job_valid && rsp.done_id == '0)
		else $error("execute on empty queue returned a job");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.job_valid && rsp.insert_rejected))
		else $error("result both executed and rejected");

endmodule

`default_nettype wire

@@ sim/tb_arrival_burst_priority_queue.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arrival_burst_priority_queue - job queue check against a sorted job list
// Drives insert and execute transactions through the request channel. A job
// list sorted by arrival, then burst, predicts every result: the popped job,
// the full-queue flag, the held count, and the saturating arrival update.
// Results are compared in order. Both channels idle and stall in random
// bursts, except near the end of the run.
// ----------------------------------------------------------------------------

module tb_arrival_burst_priority_queue;
	import abpq_pkg::*;

	localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
	localparam int unsigned RANDOM_ITEMS = 1750;
	localparam int unsigned QUIET_TAIL   = 150;
	localparam longint      ARRIVAL_FLOOR = -64'sd2147483648;
	localparam logic signed [ARR_W-1:0] ARRIVAL_MIN = {1'b1, {(ARR_W-1){1'b0}}};
	localparam logic signed [ARR_W-1:0] ARRIVAL_MAX = {1'b0, {(ARR_W-1){1'b1}}};

	typedef struct {
		op_t                     op;
		logic [ID_W-1:0]         id;
		logic [BURST_W-1:0]      burst;
		logic signed [ARR_W-1:0] arrival;
	} job_req_t;

	typedef struct {
		logic [ID_W-1:0]         id;
		logic [BURST_W-1:0]      burst;
		logic signed [ARR_W-1:0] arrival;
	} held_job_t;

	typedef struct {
		logic                job_valid;
		logic [ID_W-1:0]     done_id;
		logic [BURST_W-1:0]  done_burst;
		logic                insert_rejected;
		logic [QCOUNT_W-1:0] queue_count;
	} job_result_t;

	logic clk;
	logic arst_n;

	abpq_req_if req();
	abpq_rsp_if rsp();

	arrival_burst_priority_queue #(
		.QUEUE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	job_req_t    pending_requests[$];
	job_result_t expected_results[$];
	held_job_t   held_jobs[$];

	int unsigned error_count      = 0;
	int unsigned insert_count     = 0;
	int unsigned reject_count     = 0;
	int unsigned execute_count    = 0;
	int unsigned empty_exec_count = 0;
	int unsigned total_requests   = 0;
	int unsigned accepted_count   = 0;
	int unsigned gap_left         = 0;
	int unsigned stall_left       = 0;
	logic        req_taken        = 1'b0;
	logic        settle_phase     = 1'b0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic job_result_t schedule_job(job_req_t r);
		job_result_t res;
		held_job_t   j;
		int unsigned pos;
		longint      diff;
		res = '{default: '0};
		if (r.op == OP_INSERT) begin
			insert_count++;
			if (held_jobs.size() >= DEPTH) begin
				res.insert_rejected = 1'b1;
				reject_count++;
			end else begin
				pos = 0;
				while (pos < held_jobs.size() &&
						(held_jobs[pos].arrival != r.arrival ?
						held_jobs[pos].arrival < r.arrival :
						held_jobs[pos].burst <= r.burst))
					pos++;
				j = '{id: r.id, burst: r.burst, arrival: r.arrival};
				held_jobs.insert(pos, j);
			end
		end else begin
			execute_count++;
			if (held_jobs.size() == 0) begin
				empty_exec_count++;
			end else begin
				j = held_jobs.pop_front();
				res.job_valid  = 1'b1;
				res.done_id    = j.id;
				res.done_burst = j.burst;
				foreach (held_jobs[i]) begin
					diff = longint'(held_jobs[i].arrival) - longint'(j.burst);
					held_jobs[i].arrival = (diff < ARRIVAL_FLOOR) ? ARRIVAL_MIN : diff[ARR_W-1:0];
				end
			end
		end
		res.queue_count = QCOUNT_W'(held_jobs.size());
		return res;
	endfunction

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	task automatic add_insert(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
			logic signed [ARR_W-1:0] arrival);
		pending_requests.push_back('{op: OP_INSERT, id: id, burst: burst, arrival: arrival});
	endtask

	task automatic add_execute();
		pending_requests.push_back('{op: OP_EXECUTE, id: ID_W'($urandom),
			burst: BURST_W'($urandom), arrival: $urandom});
	endtask

	// check results, then predict the transaction accepted at this edge
	always @(posedge clk) begin : result_check
		job_result_t want;
		job_req_t    seen;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t ns: unexpected result, expected none, actual id %0h burst %0h",
						$time, rsp.done_id, rsp.done_burst);
				end else begin
					want = expected_results.pop_front();
					check_field("job_valid", want.job_valid, rsp.job_valid);
					check_field("done_id", want.done_id, rsp.done_id);
					check_field("done_burst", want.done_burst, rsp.done_burst);
					check_field("insert_rejected", want.insert_rejected, rsp.insert_rejected);
					check_field("queue_count", want.queue_count, rsp.queue_count);
				end
			end
			if (req.valid && req.ready) begin
				seen = '{op: op_t'(req.operation), id: req.job_id, burst: req.burst_time,
					arrival: req.arrival_time};
				expected_results.push_back(schedule_job(seen));
				accepted_count++;
			end
			req_taken    <= req.valid && req.ready;
			settle_phase <= total_requests - accepted_count <= QUIET_TAIL;
		end
	end

	always @(negedge clk) begin : request_driver
		logic drive;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req_taken)
				void'(pending_requests.pop_front());
			drive = req.valid && !req_taken;
			if (!drive) begin
				if (gap_left > 0)
					gap_left--;
				else if (!settle_phase && $urandom_range(0, 9) == 0)
					gap_left = $urandom_range(0, 13);
				else if (pending_requests.size() > 0)
					drive = 1'b1;
			end
			if (drive) begin
				req.operation    <= pending_requests[0].op;
				req.job_id       <= pending_requests[0].id;
				req.burst_time   <= pending_requests[0].burst;
				req.arrival_time <= pending_requests[0].arrival;
			end
			req.valid <= drive;
		end
	end

	always @(negedge clk) begin : result_stall
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else if (!settle_phase && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 13);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int unsigned             n;
		int unsigned             phase_len;
		int unsigned             insert_pct;
		logic [BURST_W-1:0]      burst;
		logic signed [ARR_W-1:0] arrival;
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.operation    = OP_INSERT;
		req.job_id       = '0;
		req.burst_time   = '0;
		req.arrival_time = '0;
		rsp.ready        = 1'b0;

		add_execute();
		add_insert(16'hFFFF, 16'hFFFF, ARRIVAL_MIN);
		add_insert(16'h0001, 16'h0005, ARRIVAL_MIN + 10);
		add_insert(16'h0002, 16'h0003, ARRIVAL_MIN + 10);
		add_insert(16'h0003, 16'h0000, ARRIVAL_MAX);
		add_insert(16'h0000, 16'h0000, ARRIVAL_MAX);
		add_insert(16'h0004, 16'h0005, ARRIVAL_MIN + 10);
		// pop the long head job; the three jobs near the minimum arrival saturate together
		add_execute();
		add_execute();
		add_execute();
		// fill to the top, then push two more into the full queue
		repeat (15)
			add_insert(ID_W'($urandom), BURST_W'($urandom), $urandom);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			phase_len = $urandom_range(8, 48);
			case ($urandom_range(0, 2))
				0: insert_pct = 85;
				1: insert_pct = 50;
				default: insert_pct = 15;
			endcase
			repeat (phase_len) begin
				if ($urandom_range(1, 100) > insert_pct) begin
					add_execute();
				end else begin
					case ($urandom_range(0, 3))
						0: arrival = $urandom_range(0, 16) - 8;
						1: arrival = ARRIVAL_MIN + $urandom_range(0, 32'h3FFFF);
						2: arrival = ARRIVAL_MAX - $urandom_range(0, 255);
						default: arrival = $urandom;
					endcase
					case ($urandom_range(0, 3))
						0: burst = $urandom_range(0, 7);
						1: burst = 16'hFFFF;
						2: burst = $urandom_range(0, 255);
						default: burst = $urandom_range(0, 16'hFFFF);
					endcase
					add_insert($urandom_range(0, 16'hFFFF), burst, arrival);
				end
				n++;
			end
		end
		total_requests = pending_requests.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d transactions: %0d inserts with %0d refused on a full queue,",
			accepted_count, insert_count, reject_count);
		$display("%0d executes with %0d on an empty queue", execute_count, empty_exec_count);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#5ms;
		$display("status: fail");
		$finish;
	end

endmodule
